@@ sv/spr_pkg.sv @@
// Shared constants, codes and types for the serial packet receiver.
`timescale 1ns / 1ps

package spr_pkg;

    localparam int TEXT_DEPTH = 128;
    localparam int TEXT_AW    = $clog2(TEXT_DEPTH);
    localparam int TEXT_CAP   = TEXT_DEPTH - 1;
    localparam int HEX_BYTES  = 4;
    localparam int HEX_IW     = (HEX_BYTES > 1) ? $clog2(HEX_BYTES) : 1;
    localparam int HEX_W      = 8 * HEX_BYTES;

    localparam logic [7:0] BYTE_HDR_HEX = 8'hFF;
    localparam logic [7:0] BYTE_TRL_HEX = 8'hFE;
    localparam logic [7:0] BYTE_HDR_TXT = 8'h40;
    localparam logic [7:0] BYTE_CR      = 8'h0D;
    localparam logic [7:0] BYTE_LF      = 8'h0A;

    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_POLL = 2'd2;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_TRAILER = 2'd2;

    localparam logic KIND_HEX  = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    typedef struct packed {
        logic               we;
        logic [TEXT_AW-1:0] addr;
        logic [7:0]         data;
    } wr_t;

    typedef struct packed {
        logic [7:0]         read_char;
        logic               flag_value;
        logic               packet_done;
        logic               done_kind;
        logic [HEX_W-1:0]   hex_word;
        logic [TEXT_AW-1:0] text_length;
        logic               text_overflow;
        logic [1:0]         parse_phase;
    } res_t;

endpackage

@@ sv/spr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module spr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/spr_parser.sv @@
// Framing state machine: parse state, hex register, text length and received flag.
`timescale 1ns / 1ps

module spr_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic [1:0]                  req_type,
    input  logic [7:0]                  rx_byte,
    input  logic [spr_pkg::TEXT_AW-1:0] read_index,
    input  logic [7:0]                  store_char,
    output spr_pkg::wr_t                wr,
    output spr_pkg::res_t               res
);

    import spr_pkg::*;

    logic [1:0]         phase_reg, phase_next;
    logic [TEXT_AW-1:0] pos_reg, pos_next;
    logic               hex_mode_reg, hex_mode_next;
    logic               text_mode_reg, text_mode_next;
    logic               flag_reg, flag_next;
    logic [TEXT_AW-1:0] len_reg, len_next;
    logic               ovf_reg, ovf_next;
    logic               drop_reg, drop_next;
    logic [7:0]         hex_reg  [HEX_BYTES];
    logic [7:0]         hex_next [HEX_BYTES];
    logic               done;
    logic               kind;
    logic [TEXT_AW-1:0] pos_inc;

    assign pos_inc = pos_reg + TEXT_AW'(1);

    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        hex_mode_next  = hex_mode_reg;
        text_mode_next = text_mode_reg;
        flag_next      = flag_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        drop_next      = drop_reg;
        hex_next       = hex_reg;
        done           = 1'b0;
        kind           = KIND_HEX;
        wr.we          = 1'b0;
        wr.addr        = pos_reg;
        wr.data        = rx_byte;
        case (req_type)
            REQ_BYTE: begin
                case (phase_reg)
                    PH_PAYLOAD: begin
                        if (hex_mode_reg) begin
                            if (pos_reg < TEXT_AW'(HEX_BYTES)) begin
                                hex_next[pos_reg[HEX_IW-1:0]] = rx_byte;
                            end
                            pos_next = pos_inc;
                            if (pos_inc >= TEXT_AW'(HEX_BYTES)) begin
                                pos_next   = '0;
                                phase_next = PH_TRAILER;
                            end
                        end else if (text_mode_reg) begin
                            if (rx_byte == BYTE_CR) begin
                                phase_next = PH_TRAILER;
                            end else if (pos_reg < TEXT_AW'(TEXT_CAP)) begin
                                wr.we    = advance;
                                pos_next = pos_inc;
                            end else begin
                                drop_next = 1'b1;
                            end
                        end else begin
                            phase_next = PH_HEADER;
                        end
                    end
                    PH_TRAILER: begin
                        if (hex_mode_reg) begin
                            if (rx_byte == BYTE_TRL_HEX) begin
                                phase_next    = PH_HEADER;
                                hex_mode_next = 1'b0;
                                flag_next     = 1'b1;
                                done          = 1'b1;
                                kind          = KIND_HEX;
                            end
                        end else if (text_mode_reg) begin
                            if (rx_byte == BYTE_LF) begin
                                phase_next     = PH_HEADER;
                                text_mode_next = 1'b0;
                                flag_next      = 1'b1;
                                len_next       = pos_reg;
                                ovf_next       = drop_reg;
                                drop_next      = 1'b0;
                                done           = 1'b1;
                                kind           = KIND_TEXT;
                            end
                        end else begin
                            phase_next = PH_HEADER;
                        end
                    end
                    default: begin
                        phase_next = PH_HEADER;
                        if (rx_byte == BYTE_HDR_HEX) begin
                            phase_next    = PH_PAYLOAD;
                            pos_next      = '0;
                            hex_mode_next = 1'b1;
                        end else if (rx_byte == BYTE_HDR_TXT) begin
                            phase_next     = PH_PAYLOAD;
                            pos_next       = '0;
                            text_mode_next = 1'b1;
                            drop_next      = 1'b0;
                        end
                    end
                endcase
            end
            REQ_POLL: begin
                flag_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res.read_char     = '0;
        res.flag_value    = 1'b0;
        res.packet_done   = done;
        res.done_kind     = kind;
        res.text_length   = len_next;
        res.text_overflow = ovf_next;
        res.parse_phase   = phase_next;
        for (int i = 0; i < HEX_BYTES; i++) begin
            res.hex_word[8*i +: 8] = hex_next[i];
        end
        if (req_type == REQ_READ && read_index < len_reg) begin
            res.read_char = store_char;
        end
        if (req_type == REQ_POLL) begin
            res.flag_value = flag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            hex_mode_reg  <= 1'b0;
            text_mode_reg <= 1'b0;
            flag_reg      <= 1'b0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            drop_reg      <= 1'b0;
            for (int i = 0; i < HEX_BYTES; i++) begin
                hex_reg[i] <= '0;
            end
        end else if (advance) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            hex_mode_reg  <= hex_mode_next;
            text_mode_reg <= text_mode_next;
            flag_reg      <= flag_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            drop_reg      <= drop_next;
            hex_reg       <= hex_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HEADER) |-> (!hex_mode_reg && !text_mode_reg))
        else $error("packet mode left set while awaiting header");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && done) |=> (phase_reg == PH_HEADER && flag_reg))
        else $error("completed packet did not return to header with flag set");

    assert property (@(posedge aclk) disable iff (!aresetn)
        wr.we |-> (text_mode_reg && pos_reg < TEXT_AW'(TEXT_CAP)))
        else $error("text store write outside a text payload or past capacity");

endmodule

@@ sv/serial_packet_receiver.sv @@
// Top level: request register, text store, framing state machine and result register.
//
//   channel  dir  fields
//   s_       in   tuser: req_type; tdata: rx_byte, read_index
//   m_       out  tdata: read_char, flag_value, packet_done, done_kind,
//                        hex_word, text_length, text_overflow, parse_phase
//
// One request per cycle while m_tready is high; request register, then result register.
// The text store read port is addressed at acceptance; a write by the request
// ahead of it in the same cycle is forwarded.
// Reset clears parse state, flag, length and hex register; the text store is not
// cleared and entries below the stored length are always written ones.
// A full result register with m_tready low stalls a held request, which drops s_tready.
`timescale 1ns / 1ps

module serial_packet_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte[7:0], read_index[14:8], zero[15]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // read_char[7:0], flag_value[8], packet_done[9],
                                   // done_kind[10], hex_word[42:11], text_length[49:43],
                                   // text_overflow[50], parse_phase[52:51], zero[55:53]
);

    import spr_pkg::*;

    logic               in_valid_reg;
    logic [1:0]         in_req_reg;
    logic [7:0]         in_byte_reg;
    logic [TEXT_AW-1:0] in_idx_reg;
    logic               byp_reg;
    logic [7:0]         byp_data_reg;
    logic               out_valid_reg;
    res_t               out_reg;
    logic               advance;
    logic               accept;
    logic [7:0]         ram_rdata;
    logic [7:0]         store_char;
    logic [TEXT_AW-1:0] s_idx;
    wr_t                wr;
    res_t               res;

    assign s_idx      = s_tdata[8 +: TEXT_AW];
    assign advance    = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || advance;
    assign accept     = s_tvalid && s_tready;
    assign store_char = byp_reg ? byp_data_reg : ram_rdata;

    spr_ram #(
        .WIDTH (8),
        .DEPTH (TEXT_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (wr.we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (accept),
        .raddr (s_idx),
        .rdata (ram_rdata)
    );

    spr_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .req_type   (in_req_reg),
        .rx_byte    (in_byte_reg),
        .read_index (in_idx_reg),
        .store_char (store_char),
        .wr         (wr),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_req_reg   <= s_tuser;
            in_byte_reg  <= s_tdata[7:0];
            in_idx_reg   <= s_idx;
            byp_reg      <= wr.we && (wr.addr == s_idx);
            byp_data_reg <= wr.data;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_reg.parse_phase,
                       out_reg.text_overflow,
                       out_reg.text_length,
                       out_reg.hex_word,
                       out_reg.done_kind,
                       out_reg.packet_done,
                       out_reg.flag_value,
                       out_reg.read_char};

endmodule

@@ tb/tb_serial_packet_receiver.sv @@
// Testbench for the serial packet receiver: directed framing checks, backpressure and random traffic.
`timescale 1ns / 1ps

module tb_serial_packet_receiver;

    import spr_pkg::*;

    localparam logic [1:0] REQ_NOP = 2'd3;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // rx_byte[7:0], read_index[14:8], zero[15]
    logic [1:0]  s_tuser  = '0;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [55:0] m_tdata;         // read_char[7:0], flag_value[8], packet_done[9],
                                  // done_kind[10], hex_word[42:11], text_length[49:43],
                                  // text_overflow[50], parse_phase[52:51], zero[55:53]

    serial_packet_receiver uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // deframer state mirror
    logic [1:0]  rx_phase;
    int          rx_pos;
    bit          rx_hex;
    bit          rx_text;
    bit          rx_flag;
    logic [7:0]  hex_mem [HEX_BYTES];
    logic [7:0]  text_mem [TEXT_DEPTH];
    logic [6:0]  rx_len;
    bit          rx_ovf;
    bit          rx_drop;
    bit          byte_ignored;

    res_t        expected_replies [$];

    int          mismatches    = 0;
    int          replies_seen  = 0;
    int          live_requests = 0;
    int          hex_done      = 0;
    int          text_done     = 0;
    int          reads_sent    = 0;
    int          polls_sent    = 0;
    int          overflow_pkts = 0;

    int          burst_left   = 0;
    int          hold_request = 0;
    int          hold_left    = 0;
    int          stall_mode   = 0;
    int          mode_left    = 0;
    int          pattern_step = 0;

    res_t        got_reply;
    res_t        want_reply;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(3_000_000);
        $display("Some tests failed");
        $finish;
    end

    task automatic take_rx_byte(input logic [7:0] b, output logic done, output logic kind);
        done = 1'b0;
        kind = KIND_HEX;
        if (rx_phase == PH_PAYLOAD) begin
            if (rx_hex) begin
                if (rx_pos < HEX_BYTES) hex_mem[rx_pos] = b;
                rx_pos++;
                if (rx_pos >= HEX_BYTES) begin
                    rx_pos   = 0;
                    rx_phase = PH_TRAILER;
                end
            end else if (rx_text) begin
                if (b == BYTE_CR) begin
                    rx_phase = PH_TRAILER;
                end else if (rx_pos < TEXT_CAP) begin
                    text_mem[rx_pos] = b;
                    rx_pos++;
                end else begin
                    rx_drop = 1'b1;
                end
            end else begin
                rx_phase = PH_HEADER;
            end
        end else if (rx_phase == PH_TRAILER) begin
            if (rx_hex) begin
                if (b == BYTE_TRL_HEX) begin
                    rx_phase = PH_HEADER;
                    rx_hex   = 1'b0;
                    rx_flag  = 1'b1;
                    done     = 1'b1;
                    kind     = KIND_HEX;
                    hex_done++;
                end else begin
                    byte_ignored = 1'b1;
                end
            end else if (rx_text) begin
                if (b == BYTE_LF) begin
                    rx_phase = PH_HEADER;
                    rx_text  = 1'b0;
                    rx_flag  = 1'b1;
                    rx_len   = rx_pos[6:0];
                    rx_ovf   = rx_drop;
                    rx_drop  = 1'b0;
                    done     = 1'b1;
                    kind     = KIND_TEXT;
                    text_done++;
                    if (rx_ovf) overflow_pkts++;
                end else begin
                    byte_ignored = 1'b1;
                end
            end else begin
                rx_phase = PH_HEADER;
            end
        end else begin
            rx_phase = PH_HEADER;
            if (b == BYTE_HDR_HEX) begin
                rx_phase = PH_PAYLOAD;
                rx_pos   = 0;
                rx_hex   = 1'b1;
            end else if (b == BYTE_HDR_TXT) begin
                rx_phase = PH_PAYLOAD;
                rx_pos   = 0;
                rx_text  = 1'b1;
                rx_drop  = 1'b0;
            end else begin
                byte_ignored = 1'b1;
            end
        end
    endtask

    task automatic advance_deframer(input logic [1:0] req, input logic [7:0] b,
                                    input logic [6:0] idx);
        res_t r;
        logic done;
        logic kind;
        r = '0;
        byte_ignored = 1'b0;
        case (req)
            REQ_BYTE: begin
                take_rx_byte(b, done, kind);
                r.packet_done = done;
                r.done_kind   = kind;
            end
            REQ_READ: begin
                reads_sent++;
                if (idx < rx_len) r.read_char = text_mem[idx];
            end
            REQ_POLL: begin
                polls_sent++;
                r.flag_value = rx_flag;
                rx_flag      = 1'b0;
            end
            default: ;
        endcase
        for (int i = 0; i < HEX_BYTES; i++) r.hex_word[8*i +: 8] = hex_mem[i];
        r.text_length   = rx_len;
        r.text_overflow = rx_ovf;
        r.parse_phase   = rx_phase;
        expected_replies.push_back(r);
        if (!byte_ignored) live_requests++;
    endtask

    task automatic send_req(input logic [1:0] req, input logic [7:0] b, input logic [6:0] idx);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {1'b0, idx, b};
        do @(posedge aclk); while (!s_tready);
        advance_deframer(req, b, idx);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_req(REQ_BYTE, b, 7'($urandom_range(0, 127)));
    endtask

    task automatic send_read(input logic [6:0] idx);
        send_req(REQ_READ, 8'($urandom_range(0, 255)), idx);
    endtask

    task automatic send_poll();
        send_req(REQ_POLL, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    endtask

    // drop valid, then hold until every reply is back
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [7:0] text_char();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == BYTE_CR);
        return v;
    endfunction

    task automatic send_hex_packet();
        send_byte(BYTE_HDR_HEX);
        for (int i = 0; i < HEX_BYTES; i++) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0) send_byte(8'($urandom_range(0, 253)));
        send_byte(BYTE_TRL_HEX);
    endtask

    task automatic send_text_packet(input int n);
        send_byte(BYTE_HDR_TXT);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) send_read(7'($urandom_range(0, 127)));
            send_byte(text_char());
        end
        send_byte(BYTE_CR);
        if ($urandom_range(0, 4) == 0) send_byte(8'($urandom_range(11, 255)));
        send_byte(BYTE_LF);
    endtask

    task automatic test_idle_status();
        send_poll();
        send_read(7'd0);
        send_req(REQ_NOP, 8'hFF, 7'd127);
        send_byte(8'h00);
    endtask

    task automatic test_hex_framing();
        send_byte(BYTE_HDR_HEX);
        send_byte(8'h00);
        send_byte(BYTE_HDR_HEX);
        send_byte(BYTE_TRL_HEX);
        send_byte(BYTE_HDR_TXT);
        send_byte(8'h7F);
        send_byte(BYTE_TRL_HEX);
    endtask

    task automatic test_text_framing();
        send_byte(BYTE_HDR_TXT);
        send_byte(8'h41);
        send_byte(BYTE_LF);
        send_byte(BYTE_HDR_HEX);
        send_byte(BYTE_CR);
        send_byte(BYTE_TRL_HEX);
        send_byte(BYTE_LF);
    endtask

    task automatic test_flag_poll();
        send_poll();
        send_poll();
    endtask

    task automatic test_store_reads();
        send_read(7'd2);
        send_read(7'd127);
        send_byte(BYTE_HDR_TXT);
        send_byte(8'h5A);
        send_read(7'd0);
        send_byte(BYTE_CR);
        send_byte(BYTE_LF);
    endtask

    task automatic test_text_overflow();
        send_text_packet($urandom_range(TEXT_CAP + 1, TEXT_CAP + 6));
        send_read(7'(TEXT_CAP - 1));
        send_read(7'(TEXT_CAP));
        send_text_packet(3);
    endtask

    task automatic test_backpressure();
        hold_request = 150;
        for (int i = 0; i < 6; i++) send_hex_packet();
        send_poll();
    endtask

    task automatic test_random_traffic(input int target);
        int start;
        int pick;
        int n;
        start = live_requests;
        while (live_requests - start < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_hex_packet();
            end else if (pick < 55) begin
                n = $urandom_range(0, 99);
                if (n < 90) send_text_packet($urandom_range(0, 16));
                else if (n < 98) send_text_packet($urandom_range(0, TEXT_CAP));
                else send_text_packet($urandom_range(TEXT_CAP - 6, TEXT_CAP + 12));
            end else if (pick < 70) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 9) < 7)
                        send_read(7'($urandom_range(0, (rx_len < 126) ? rx_len + 1 : 127)));
                    else
                        send_read(7'($urandom_range(0, 127)));
                end
            end else if (pick < 78) begin
                send_poll();
            end else if (pick < 83) begin
                send_req(REQ_NOP, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
            end else begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("reply %0d: %s expected 0x%0h, got 0x%0h", replies_seen, field, want, got);
    endtask

    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(40, 300);
        end
        mode_left--;
        pattern_step++;
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 9) >= 3);
                default: m_tready <= (pattern_step % 5 < 3);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            replies_seen++;
            got_reply.read_char     = m_tdata[7:0];
            got_reply.flag_value    = m_tdata[8];
            got_reply.packet_done   = m_tdata[9];
            got_reply.done_kind     = m_tdata[10];
            got_reply.hex_word      = m_tdata[42:11];
            got_reply.text_length   = m_tdata[49:43];
            got_reply.text_overflow = m_tdata[50];
            got_reply.parse_phase   = m_tdata[52:51];
            if (expected_replies.size() == 0) begin
                note_mismatch("unexpected reply", '0, m_tdata[31:0]);
            end else begin
                want_reply = expected_replies.pop_front();
                if (got_reply.read_char !== want_reply.read_char)
                    note_mismatch("read_char", want_reply.read_char, got_reply.read_char);
                if (got_reply.flag_value !== want_reply.flag_value)
                    note_mismatch("flag_value", want_reply.flag_value, got_reply.flag_value);
                if (got_reply.packet_done !== want_reply.packet_done)
                    note_mismatch("packet_done", want_reply.packet_done, got_reply.packet_done);
                if (got_reply.done_kind !== want_reply.done_kind)
                    note_mismatch("done_kind", want_reply.done_kind, got_reply.done_kind);
                if (got_reply.hex_word !== want_reply.hex_word)
                    note_mismatch("hex_word", want_reply.hex_word, got_reply.hex_word);
                if (got_reply.text_length !== want_reply.text_length)
                    note_mismatch("text_length", want_reply.text_length, got_reply.text_length);
                if (got_reply.text_overflow !== want_reply.text_overflow)
                    note_mismatch("text_overflow", want_reply.text_overflow,
                                  got_reply.text_overflow);
                if (got_reply.parse_phase !== want_reply.parse_phase)
                    note_mismatch("parse_phase", want_reply.parse_phase, got_reply.parse_phase);
            end
        end
    end

    initial begin
        rx_phase = PH_HEADER;
        rx_pos   = 0;
        rx_hex   = 1'b0;
        rx_text  = 1'b0;
        rx_flag  = 1'b0;
        rx_len   = '0;
        rx_ovf   = 1'b0;
        rx_drop  = 1'b0;
        for (int i = 0; i < HEX_BYTES; i++) hex_mem[i] = '0;
        for (int i = 0; i < TEXT_DEPTH; i++) text_mem[i] = '0;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_idle_status();
        test_hex_framing();
        test_text_framing();
        test_flag_poll();
        test_store_reads();
        settle();
        test_text_overflow();
        settle();
        test_backpressure();
        settle();
        test_random_traffic(1500);
        settle();

        $display("Covered %0d effective requests and %0d replies: %0d hex and %0d text packets,",
                 live_requests, replies_seen, hex_done, text_done);
        $display("%0d text packets with dropped characters, %0d store reads, %0d flag polls.",
                 overflow_pkts, reads_sent, polls_sent);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
